// ----- sv/rrc_pkg.sv -----
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants for the RR interval run counter: register
// indexes, reset values, field widths and the configuration record.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int TOTAL_WIDTH_DEF = 32;
  localparam int RUN_WIDTH_DEF   = 8;

  localparam int TIME_W  = 32;
  localparam int VOLT_W  = 16;
  localparam int INTV_W  = 16;
  localparam int LEN_W   = 8;
  localparam int OUT_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  typedef enum logic [CIDX_W-1:0] {
    REG_VOLT_MIN      = 3'd0,
    REG_VOLT_MAX      = 3'd1,
    REG_SLOW_INTERVAL = 3'd2,
    REG_FAST_INTERVAL = 3'd3,
    REG_SLOW_RUN_LEN  = 3'd4,
    REG_FAST_RUN_LEN  = 3'd5
  } reg_index_t;

  localparam logic signed [VOLT_W-1:0] VOLT_MIN_RST      = 16'sd12;
  localparam logic signed [VOLT_W-1:0] VOLT_MAX_RST      = 16'sd16;
  localparam logic        [INTV_W-1:0] SLOW_INTERVAL_RST = 16'd120;
  localparam logic        [INTV_W-1:0] FAST_INTERVAL_RST = 16'd50;
  localparam logic        [LEN_W-1:0]  SLOW_RUN_LEN_RST  = 8'd4;
  localparam logic        [LEN_W-1:0]  FAST_RUN_LEN_RST  = 8'd8;

  typedef struct packed {
    logic signed [VOLT_W-1:0] volt_min;
    logic signed [VOLT_W-1:0] volt_max;
    logic        [INTV_W-1:0] slow_interval;
    logic        [INTV_W-1:0] fast_interval;
    logic        [LEN_W-1:0]  slow_run_len;
    logic        [LEN_W-1:0]  fast_run_len;
  } rrc_cfg_t;

endpackage

// ----- sv/rr_interval_rate_run_counter.sv -----
// ----------------------------------------------------------------------------
// rr_interval_rate_run_counter
// Counts beats in slow (brady) and fast (tachy) RR interval runs.
//
// Beats enter on the in channel (func, peak_time, peak_volt) with in_valid
// and in_ready. A beat is valid when its voltage lies inside the configured
// window; each pair of consecutive valid beats gives an RR interval that
// extends or ends the slow and fast runs. func set clears all beat state
// and both totals. Every input word yields one output word carrying the
// totals after that word, on out_valid/out_ready.
// Registers are to be written on the cfg channel, which is always ready,
// only while no beat is in flight; the block itself does not enforce this.
// An accepted word sits in the input register; when it advances, the interval,
// run and total update for it is loaded into the output register.
// Throughput is one word per cycle while out_ready is high; the only loop is
// the state update. When the receiver stalls, the output register holds and
// one more word waits in the input register before in_ready falls.
// Synchronous reset restores the register defaults and clears all state.
// ----------------------------------------------------------------------------
module rr_interval_rate_run_counter
  import rrc_pkg::*;
#(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF,
  parameter int RUN_WIDTH   = RUN_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CDATA_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic signed [TIME_W-1:0] peak_time,
  input  logic signed [VOLT_W-1:0] peak_volt,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_W-1:0]         slow_total,
  output logic [OUT_W-1:0]         fast_total
);

  localparam int EXT_W = (TOTAL_WIDTH > OUT_W) ? TOTAL_WIDTH : OUT_W;

  rrc_cfg_t cfg;

  logic                     in_full;
  logic                     func_r;
  logic signed [TIME_W-1:0] time_r;
  logic signed [VOLT_W-1:0] volt_r;

  logic signed [TIME_W-1:0] last_time;
  logic                     last_valid;
  logic [RUN_WIDTH-1:0]     slow_run;
  logic [RUN_WIDTH-1:0]     fast_run;
  logic [TOTAL_WIDTH-1:0]   slow_sum;
  logic [TOTAL_WIDTH-1:0]   fast_sum;

  logic                     advance;
  logic                     beat_valid;
  logic                     pair_valid;
  logic signed [TIME_W:0]   interval;
  logic                     slow_hit;
  logic                     fast_hit;
  logic [RUN_WIDTH-1:0]     slow_run_next;
  logic [RUN_WIDTH-1:0]     fast_run_next;
  logic [TOTAL_WIDTH-1:0]   slow_sum_next;
  logic [TOTAL_WIDTH-1:0]   fast_sum_next;
  logic [EXT_W-1:0]         slow_ext;
  logic [EXT_W-1:0]         fast_ext;

  rrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_comb begin
    beat_valid = (volt_r >= cfg.volt_min) && (volt_r <= cfg.volt_max);
    pair_valid = beat_valid && last_valid;
    // The interval is the exact 33-bit difference and never wraps.
    interval   = {time_r[TIME_W-1], time_r} - {last_time[TIME_W-1], last_time};
    slow_hit   = pair_valid && (interval >= $signed({17'b0, cfg.slow_interval}));
    fast_hit   = pair_valid && (interval <= $signed({17'b0, cfg.fast_interval}));
  end

  rrc_run_step #(
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .RUN_WIDTH   (RUN_WIDTH)
  ) u_slow (
    .hit      (slow_hit),
    .run      (slow_run),
    .run_len  (cfg.slow_run_len),
    .sum      (slow_sum),
    .run_next (slow_run_next),
    .sum_next (slow_sum_next)
  );

  rrc_run_step #(
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .RUN_WIDTH   (RUN_WIDTH)
  ) u_fast (
    .hit      (fast_hit),
    .run      (fast_run),
    .run_len  (cfg.fast_run_len),
    .sum      (fast_sum),
    .run_next (fast_run_next),
    .sum_next (fast_sum_next)
  );

  assign slow_ext = EXT_W'(slow_sum_next);
  assign fast_ext = EXT_W'(fast_sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      func_r <= func;
      time_r <= peak_time;
      volt_r <= peak_volt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_valid <= 1'b0;
      slow_run   <= '0;
      fast_run   <= '0;
      slow_sum   <= '0;
      fast_sum   <= '0;
    end else if (advance) begin
      if (func_r) begin
        last_time  <= '0;
        last_valid <= 1'b0;
        slow_run   <= '0;
        fast_run   <= '0;
        slow_sum   <= '0;
        fast_sum   <= '0;
      end else begin
        last_time  <= time_r;
        last_valid <= beat_valid;
        slow_run   <= slow_run_next;
        fast_run   <= fast_run_next;
        slow_sum   <= slow_sum_next;
        fast_sum   <= fast_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      slow_total <= func_r ? '0 : slow_ext[OUT_W-1:0];
      fast_total <= func_r ? '0 : fast_ext[OUT_W-1:0];
    end
  end

endmodule

// ----- sv/rrc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rrc_cfg_regs
// Configuration register file: six registers written by index over a
// valid/ready write channel that is always ready.
// ----------------------------------------------------------------------------
module rrc_cfg_regs
  import rrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output rrc_cfg_t           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_min      <= VOLT_MIN_RST;
      cfg.volt_max      <= VOLT_MAX_RST;
      cfg.slow_interval <= SLOW_INTERVAL_RST;
      cfg.fast_interval <= FAST_INTERVAL_RST;
      cfg.slow_run_len  <= SLOW_RUN_LEN_RST;
      cfg.fast_run_len  <= FAST_RUN_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VOLT_MIN:      cfg.volt_min      <= $signed(cfg_data[VOLT_W-1:0]);
        REG_VOLT_MAX:      cfg.volt_max      <= $signed(cfg_data[VOLT_W-1:0]);
        REG_SLOW_INTERVAL: cfg.slow_interval <= cfg_data[INTV_W-1:0];
        REG_FAST_INTERVAL: cfg.fast_interval <= cfg_data[INTV_W-1:0];
        REG_SLOW_RUN_LEN:  cfg.slow_run_len  <= cfg_data[LEN_W-1:0];
        REG_FAST_RUN_LEN:  cfg.fast_run_len  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/rrc_run_step.sv -----
// ----------------------------------------------------------------------------
// rrc_run_step
// Next value of one run counter and its saturating total for one beat.
// ----------------------------------------------------------------------------
module rrc_run_step
  import rrc_pkg::*;
#(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF,
  parameter int RUN_WIDTH   = RUN_WIDTH_DEF
) (
  input  logic                   hit,
  input  logic [RUN_WIDTH-1:0]   run,
  input  logic [LEN_W-1:0]       run_len,
  input  logic [TOTAL_WIDTH-1:0] sum,
  output logic [RUN_WIDTH-1:0]   run_next,
  output logic [TOTAL_WIDTH-1:0] sum_next
);

  localparam int CMP_W = (RUN_WIDTH + 1 > LEN_W) ? RUN_WIDTH + 1 : LEN_W;

  logic [RUN_WIDTH:0]     count;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       len_ext;
  logic [LEN_W-1:0]       add;
  logic                   do_add;
  logic [TOTAL_WIDTH:0]   sum_wide;

  always_comb begin
    // A run that has just started is taken to be one beat long already.
    count     = ((run == '0) ? (RUN_WIDTH+1)'(1) : {1'b0, run}) + (RUN_WIDTH+1)'(1);
    count_ext = CMP_W'(count);
    len_ext   = CMP_W'(run_len);
    do_add    = (count_ext >= len_ext);
    add       = (count_ext == len_ext) ? run_len : LEN_W'(1);
    sum_wide  = {1'b0, sum} + (TOTAL_WIDTH+1)'(add);

    run_next = '0;
    sum_next = sum;
    if (hit) begin
      run_next = count[RUN_WIDTH] ? '1 : count[RUN_WIDTH-1:0];
      if (do_add) begin
        sum_next = sum_wide[TOTAL_WIDTH] ? '1 : sum_wide[TOTAL_WIDTH-1:0];
      end
    end
  end

endmodule
